/* design/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, register codes, constants and helpers of the pixel shader.
// ----------------------------------------------------------------------------
package bps_pkg;

  typedef struct packed {
    logic [7:0]         texel_red;
    logic [7:0]         texel_green;
    logic [7:0]         texel_blue;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_t;

  typedef struct packed {
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
  } out_t;

  typedef enum logic [2:0] {
    REG_LIGHT_POS      = 3'd0,
    REG_CAMERA_POS     = 3'd1,
    REG_LIGHT_INT      = 3'd2,
    REG_AMBIENT_INT    = 3'd3,
    REG_AMBIENT_COEFF  = 3'd4,
    REG_SPECULAR_COEFF = 3'd5,
    REG_SHININESS      = 3'd6
  } cfg_reg_t;

  typedef logic signed [16:0] comp_t;
  typedef logic signed [15:0] unit_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [47:0] LIGHT_POS_RST   = 48'd6400;
  localparam logic [47:0] CAMERA_POS_RST  = 48'd0;
  localparam logic [23:0] LIGHT_INT_RST   = 24'd6579300;
  localparam logic [23:0] AMBIENT_INT_RST = 24'd6579300;
  localparam logic [23:0] AMBIENT_CO_RST  = 24'd8421504;
  localparam logic [23:0] SPECULAR_CO_RST = 24'd8421504;
  localparam logic [7:0]  SHININESS_RST   = 8'd50;

  localparam int NORM_SIDE_W = 1;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_STEPS   = 14;
  localparam int EXP_W       = 8;
  localparam int POW_STEPS   = 2 * EXP_W;

  localparam logic [14:0] ONE_Q14    = 15'd16384;
  localparam logic [24:0] SAT_LIMIT  = 25'd16711680;
  localparam logic [15:0] COLOUR_MAX = 16'hFFFF;

  // (a*b + half) >> 14, operands never above one
  function automatic logic [14:0] qmul(input logic [14:0] a, input logic [14:0] b);
    logic [29:0] p;
    p = {15'b0, a} * {15'b0, b};
    p = p + 30'd8192;
    return p[28:14];
  endfunction

  // clamp a Q2.28 dot product to [0, one] in Q1.14
  function automatic logic [14:0] pos_dot(input logic signed [33:0] d);
    logic [19:0] q;
    q = d[33:14];
    if (d <= 34'sd0) begin
      return 15'd0;
    end else if (q > 20'(ONE_Q14)) begin
      return ONE_Q14;
    end else begin
      return q[14:0];
    end
  endfunction

endpackage

/* design/bps_norm.sv */
// ----------------------------------------------------------------------------
// bps_norm
// Pipelined vector normaliser: squares, digit-serial square root over
// pipeline stages, then restoring division per component, capped at one.
// ----------------------------------------------------------------------------
module bps_norm #(
  parameter int SIDE_W = bps_pkg::NORM_SIDE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  bps_pkg::comp_t     vec_i [3],
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output bps_pkg::unit_t     unit_o [3],
  output logic [SIDE_W-1:0]  side_o
);

  localparam int SQ = bps_pkg::SQRT_STEPS;
  localparam int DV = bps_pkg::DIV_STEPS;

  // squaring stage
  logic              va_r;
  logic [2:0]        neg_a_r;
  logic [2:0][15:0]  mag_a_r;
  logic [2:0][31:0]  sqr_a_r;
  logic [SIDE_W-1:0] side_a_r;
  logic [2:0][15:0]  mag_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = vec_i[i][16] ? 16'(-vec_i[i]) : vec_i[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= valid_i;
    end
    side_a_r <= side_i;
    mag_a_r  <= mag_nxt;
    for (int i = 0; i < 3; i++) begin
      neg_a_r[i] <= vec_i[i][16];
      sqr_a_r[i] <= {16'b0, mag_nxt[i]} * {16'b0, mag_nxt[i]};
    end
  end

  // square root pipeline, index 0 is the sum stage
  logic              sq_vld_r  [SQ+1];
  logic [61:0]       sq_x_r    [SQ+1];
  logic [61:0]       sq_res_r  [SQ+1];
  logic              sq_zero_r [SQ+1];
  logic [2:0]        sq_neg_r  [SQ+1];
  logic [2:0][15:0]  sq_mag_r  [SQ+1];
  logic [SIDE_W-1:0] sq_side_r [SQ+1];
  logic [33:0]       sum_nxt;

  assign sum_nxt = 34'(sqr_a_r[0]) + 34'(sqr_a_r[1]) + 34'(sqr_a_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= va_r;
    end
    sq_x_r[0]    <= {sum_nxt, 28'b0};
    sq_res_r[0]  <= '0;
    sq_zero_r[0] <= (sum_nxt == 34'd0);
    sq_neg_r[0]  <= neg_a_r;
    sq_mag_r[0]  <= mag_a_r;
    sq_side_r[0] <= side_a_r;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQ - 1 - k));
    logic [62:0] trial;
    logic [61:0] x_nxt;
    logic [61:0] res_nxt;

    always_comb begin
      trial = {1'b0, sq_res_r[k]} + {1'b0, BIT};
      if ({1'b0, sq_x_r[k]} >= trial) begin
        x_nxt   = sq_x_r[k] - trial[61:0];
        res_nxt = (sq_res_r[k] >> 1) + BIT;
      end else begin
        x_nxt   = sq_x_r[k];
        res_nxt = sq_res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      sq_x_r[k+1]    <= x_nxt;
      sq_res_r[k+1]  <= res_nxt;
      sq_zero_r[k+1] <= sq_zero_r[k];
      sq_neg_r[k+1]  <= sq_neg_r[k];
      sq_mag_r[k+1]  <= sq_mag_r[k];
      sq_side_r[k+1] <= sq_side_r[k];
    end
  end

  // division pipeline, index 0 is the set-up stage
  logic              dv_vld_r  [DV+1];
  logic [30:0]       dv_den_r  [DV+1];
  logic [2:0][31:0]  dv_rem_r  [DV+1];
  logic [2:0][13:0]  dv_q_r    [DV+1];
  logic [2:0]        dv_sat_r  [DV+1];
  logic [2:0]        dv_neg_r  [DV+1];
  logic              dv_zero_r [DV+1];
  logic [SIDE_W-1:0] dv_side_r [DV+1];
  logic [30:0]       root;

  assign root = sq_res_r[SQ][30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sq_vld_r[SQ];
    end
    dv_den_r[0]  <= root;
    dv_neg_r[0]  <= sq_neg_r[SQ];
    dv_zero_r[0] <= sq_zero_r[SQ];
    dv_side_r[0] <= sq_side_r[SQ];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= {2'b0, sq_mag_r[SQ][i], 14'b0};
      dv_sat_r[0][i] <= ({1'b0, sq_mag_r[SQ][i], 14'b0} >= root);
      dv_q_r[0][i]   <= '0;
    end
  end

  for (genvar j = 0; j < DV; j++) begin : g_div
    logic [2:0][31:0] rem_nxt;
    logic [2:0][13:0] q_nxt;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if ({dv_rem_r[j][i][30:0], 1'b0} >= {1'b0, dv_den_r[j]}) begin
          rem_nxt[i] = {dv_rem_r[j][i][30:0], 1'b0} - {1'b0, dv_den_r[j]};
          q_nxt[i]   = {dv_q_r[j][i][12:0], 1'b1};
        end else begin
          rem_nxt[i] = {dv_rem_r[j][i][30:0], 1'b0};
          q_nxt[i]   = {dv_q_r[j][i][12:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      dv_den_r[j+1]  <= dv_den_r[j];
      dv_rem_r[j+1]  <= rem_nxt;
      dv_q_r[j+1]    <= q_nxt;
      dv_sat_r[j+1]  <= dv_sat_r[j];
      dv_neg_r[j+1]  <= dv_neg_r[j];
      dv_zero_r[j+1] <= dv_zero_r[j];
      dv_side_r[j+1] <= dv_side_r[j];
    end
  end

  // sign and cap
  logic              out_vld_r;
  logic [2:0][15:0]  unit_r;
  logic [SIDE_W-1:0] side_r;
  logic [2:0][15:0]  unit_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [15:0] m;
      m = dv_sat_r[DV][i] ? {1'b0, bps_pkg::ONE_Q14} : {2'b0, dv_q_r[DV][i]};
      if (dv_zero_r[DV]) begin
        unit_nxt[i] = '0;
      end else if (dv_neg_r[DV][i]) begin
        unit_nxt[i] = -m;
      end else begin
        unit_nxt[i] = m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld_r[DV];
    end
    unit_r <= unit_nxt;
    side_r <= dv_side_r[DV];
  end

  assign valid_o = out_vld_r;
  assign side_o  = side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = unit_r[i];
    end
  end

endmodule

/* design/blinn_phong_pixel_shade.sv */
// ----------------------------------------------------------------------------
// blinn_phong_pixel_shade
// Blinn-Phong shading of one fragment under one point light.
// ----------------------------------------------------------------------------
// A fragment is taken on every cycle in which start is high; busy is always
// low. Each fragment gives one colour on out_valid/out_data, in order, one
// per cycle at full rate. Between input and output lie two normalisers in
// series (31 square-root steps and 14 division steps each) and the 16
// multiply stages of the specular power. Results cannot be held off.
// Configuration writes are taken on every cycle and should only be made
// with no fragment in flight.
module blinn_phong_pixel_shade (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  bps_pkg::in_t                     in_data,
  output logic                             out_valid,
  output bps_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TEX_W   = 24;
  localparam int HSIDE_W = TEX_W + 6 * 16;
  localparam int PW      = bps_pkg::POW_STEPS;

  // configuration
  logic [47:0] light_pos_r;
  logic [47:0] cam_pos_r;
  logic [23:0] light_int_r;
  logic [23:0] amb_int_r;
  logic [23:0] amb_co_r;
  logic [23:0] spec_co_r;
  logic [7:0]  shin_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_pos_r <= bps_pkg::LIGHT_POS_RST;
      cam_pos_r   <= bps_pkg::CAMERA_POS_RST;
      light_int_r <= bps_pkg::LIGHT_INT_RST;
      amb_int_r   <= bps_pkg::AMBIENT_INT_RST;
      amb_co_r    <= bps_pkg::AMBIENT_CO_RST;
      spec_co_r   <= bps_pkg::SPECULAR_CO_RST;
      shin_r      <= bps_pkg::SHININESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (bps_pkg::cfg_reg_t'(cfg_index))
        bps_pkg::REG_LIGHT_POS:      light_pos_r <= cfg_data;
        bps_pkg::REG_CAMERA_POS:     cam_pos_r   <= cfg_data;
        bps_pkg::REG_LIGHT_INT:      light_int_r <= cfg_data[23:0];
        bps_pkg::REG_AMBIENT_INT:    amb_int_r   <= cfg_data[23:0];
        bps_pkg::REG_AMBIENT_COEFF:  amb_co_r    <= cfg_data[23:0];
        bps_pkg::REG_SPECULAR_COEFF: spec_co_r   <= cfg_data[23:0];
        bps_pkg::REG_SHININESS:      shin_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input stage: direction vectors
  logic              v0_r;
  logic [TEX_W-1:0]  tex0_r;
  bps_pkg::comp_t    cn0_r [3];
  bps_pkg::comp_t    cl0_r [3];
  bps_pkg::comp_t    cv0_r [3];
  logic [2:0][15:0]  lp;
  logic [2:0][15:0]  cp;
  logic [2:0][15:0]  pos;
  logic [2:0][15:0]  nrm;

  assign lp  = {light_pos_r[47:32], light_pos_r[15:0], light_pos_r[31:16]};
  assign cp  = {cam_pos_r[47:32], cam_pos_r[15:0], cam_pos_r[31:16]};
  assign pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign nrm = {in_data.normal_z, in_data.normal_y, in_data.normal_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    tex0_r <= {in_data.texel_blue, in_data.texel_green, in_data.texel_red};
    for (int i = 0; i < 3; i++) begin
      cn0_r[i] <= {nrm[i][15], nrm[i]};
      cl0_r[i] <= $signed({lp[i][15], lp[i]}) - $signed({pos[i][15], pos[i]});
      cv0_r[i] <= $signed({cp[i][15], cp[i]}) - $signed({pos[i][15], pos[i]});
    end
  end

  // first normalisation: N, L and V side by side
  logic              v1;
  logic [TEX_W-1:0]  tex1;
  bps_pkg::unit_t    nu1 [3];
  bps_pkg::unit_t    lu1 [3];
  bps_pkg::unit_t    vu1 [3];

  bps_norm #(.SIDE_W(TEX_W)) u_norm_n (
    .clk(clk), .rst_n(rst_n), .valid_i(v0_r), .vec_i(cn0_r), .side_i(tex0_r),
    .valid_o(v1), .unit_o(nu1), .side_o(tex1)
  );

  bps_norm #(.SIDE_W(bps_pkg::NORM_SIDE_W)) u_norm_l (
    .clk(clk), .rst_n(rst_n), .valid_i(v0_r), .vec_i(cl0_r), .side_i(1'b0),
    .valid_o(), .unit_o(lu1), .side_o()
  );

  bps_norm #(.SIDE_W(bps_pkg::NORM_SIDE_W)) u_norm_v (
    .clk(clk), .rst_n(rst_n), .valid_i(v0_r), .vec_i(cv0_r), .side_i(1'b0),
    .valid_o(), .unit_o(vu1), .side_o()
  );

  // half vector
  logic               vh_r;
  bps_pkg::comp_t     ch_r [3];
  logic [HSIDE_W-1:0] hside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else begin
      vh_r <= v1;
    end
    hside_r <= {tex1, lu1[0], lu1[1], lu1[2], nu1[0], nu1[1], nu1[2]};
    for (int i = 0; i < 3; i++) begin
      ch_r[i] <= 17'(lu1[i]) + 17'(vu1[i]);
    end
  end

  logic               v2;
  bps_pkg::unit_t     hu2 [3];
  logic [HSIDE_W-1:0] hside2;

  bps_norm #(.SIDE_W(HSIDE_W)) u_norm_h (
    .clk(clk), .rst_n(rst_n), .valid_i(vh_r), .vec_i(ch_r), .side_i(hside_r),
    .valid_o(v2), .unit_o(hu2), .side_o(hside2)
  );

  bps_pkg::unit_t lu2 [3];
  bps_pkg::unit_t nu2 [3];

  assign lu2[0] = hside2[95:80];
  assign lu2[1] = hside2[79:64];
  assign lu2[2] = hside2[63:48];
  assign nu2[0] = hside2[47:32];
  assign nu2[1] = hside2[31:16];
  assign nu2[2] = hside2[15:0];

  // dot products
  logic                     vp_r;
  logic [TEX_W-1:0]         texp_r;
  logic signed [31:0]       pl_r [3];
  logic signed [31:0]       ph_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else begin
      vp_r <= v2;
    end
    texp_r <= hside2[HSIDE_W-1:HSIDE_W-TEX_W];
    for (int i = 0; i < 3; i++) begin
      pl_r[i] <= lu2[i] * nu2[i];
      ph_r[i] <= hu2[i] * nu2[i];
    end
  end

  logic signed [33:0] dl_nxt;
  logic signed [33:0] dh_nxt;

  assign dl_nxt = 34'(pl_r[0]) + 34'(pl_r[1]) + 34'(pl_r[2]);
  assign dh_nxt = 34'(ph_r[0]) + 34'(ph_r[1]) + 34'(ph_r[2]);

  // specular power, square then optional multiply per exponent bit
  logic              pw_vld_r  [PW+1];
  logic [14:0]       pw_r      [PW+1];
  logic [14:0]       pw_base_r [PW+1];
  logic [14:0]       pw_d_r    [PW+1];
  logic [TEX_W-1:0]  pw_tex_r  [PW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_vld_r[0] <= 1'b0;
    end else begin
      pw_vld_r[0] <= vp_r;
    end
    pw_r[0]      <= bps_pkg::ONE_Q14;
    pw_base_r[0] <= bps_pkg::pos_dot(dh_nxt);
    pw_d_r[0]    <= bps_pkg::pos_dot(dl_nxt);
    pw_tex_r[0]  <= texp_r;
  end

  for (genvar j = 0; j < PW; j++) begin : g_pow
    localparam int K = bps_pkg::EXP_W - 1 - j / 2;
    logic [14:0] pw_nxt;

    if (j % 2 == 0) begin : g_sq
      assign pw_nxt = bps_pkg::qmul(pw_r[j], pw_r[j]);
    end else begin : g_mul
      assign pw_nxt = shin_r[K] ? bps_pkg::qmul(pw_r[j], pw_base_r[j]) : pw_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_vld_r[j+1] <= 1'b0;
      end else begin
        pw_vld_r[j+1] <= pw_vld_r[j];
      end
      pw_r[j+1]      <= pw_nxt;
      pw_base_r[j+1] <= pw_base_r[j];
      pw_d_r[j+1]    <= pw_d_r[j];
      pw_tex_r[j+1]  <= pw_tex_r[j];
    end
  end

  // colour: coefficient products
  logic             c1_vld_r;
  logic [2:0][15:0] ak_r;
  logic [2:0][15:0] tl_r;
  logic [2:0][15:0] kl_r;
  logic [2:0][7:0]  t1_r;
  logic [14:0]      d1_r;
  logic [14:0]      s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= pw_vld_r[PW];
    end
    t1_r <= pw_tex_r[PW];
    d1_r <= pw_d_r[PW];
    s1_r <= pw_r[PW];
    for (int i = 0; i < 3; i++) begin
      ak_r[i] <= {8'b0, amb_int_r[8*i +: 8]} * {8'b0, amb_co_r[8*i +: 8]};
      tl_r[i] <= {8'b0, pw_tex_r[PW][8*i +: 8]} * {8'b0, light_int_r[8*i +: 8]};
      kl_r[i] <= {8'b0, spec_co_r[8*i +: 8]} * {8'b0, light_int_r[8*i +: 8]};
    end
  end

  logic             c2_vld_r;
  logic [2:0][23:0] p1_r;
  logic [2:0][30:0] p2_r;
  logic [2:0][30:0] p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_vld_r <= 1'b0;
    end else begin
      c2_vld_r <= c1_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      p1_r[i] <= 24'(ak_r[i]) * 24'(t1_r[i]);
      p2_r[i] <= 31'(tl_r[i]) * 31'(d1_r);
      p3_r[i] <= 31'(kl_r[i]) * 31'(s1_r);
    end
  end

  // sum, then scale by 2^-16
  logic             c3_vld_r;
  logic [2:0][24:0] x3_r;
  logic [2:0][40:0] num_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = (41'(p1_r[i]) << 14) + (41'(p2_r[i]) << 8)
                 + (41'(p3_r[i]) << 8) - 41'(p3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_vld_r <= 1'b0;
    end else begin
      c3_vld_r <= c2_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      x3_r[i] <= num_nxt[i][40:16];
    end
  end

  // divide by 255: estimate, then correct
  logic             c4_vld_r;
  logic [2:0]       sat4_r;
  logic [2:0][23:0] x4_r;
  logic [2:0][15:0] q4_r;
  logic [2:0][23:0] est_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      est_nxt[i] = x3_r[i][23:0] + (x3_r[i][23:0] >> 8) + (x3_r[i][23:0] >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_vld_r <= 1'b0;
    end else begin
      c4_vld_r <= c3_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      sat4_r[i] <= (x3_r[i] >= bps_pkg::SAT_LIMIT);
      x4_r[i]   <= x3_r[i][23:0];
      q4_r[i]   <= est_nxt[i][23:8];
    end
  end

  logic             out_vld_r;
  bps_pkg::out_t    out_r;
  logic [2:0][15:0] col_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [23:0] rem;
      logic [15:0] q;
      rem = x4_r[i] - ({q4_r[i], 8'b0} - 24'(q4_r[i]));
      q   = q4_r[i] + 16'(rem >= 24'd255) + 16'(rem >= 24'd510) + 16'(rem >= 24'd765);
      col_nxt[i] = sat4_r[i] ? bps_pkg::COLOUR_MAX : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= c4_vld_r;
    end
    out_r.color_red   <= col_nxt[0];
    out_r.color_green <= col_nxt[1];
    out_r.color_blue  <= col_nxt[2];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
